>>> design/tcs_pkg.sv
package tcs_pkg;

    // Quotient bits produced below the overflow threshold of 2^40.
    localparam int DIV_BITS        = 40;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = DIV_BITS / STEPS_PER_STAGE;
    // Step stages plus the rounding stage of each lane.
    localparam int DIV_LAT         = DIV_STAGES + 1;

    localparam int DVD_W = 78;   // |numerator| << 7
    localparam int DVS_W = 53;   // |triple product|

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] c_x;
        logic signed [15:0] c_y;
        logic signed [15:0] c_z;
        logic signed [15:0] d_x;
        logic signed [15:0] d_y;
        logic signed [15:0] d_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [47:0] radius_sq;
        logic               degenerate;
        logic               saturated;
    } t_out;

    // Request into one divider lane.
    typedef struct packed {
        logic [DVD_W-1:0] m;
        logic [DVS_W-1:0] d;
        logic             neg;
        logic             cap;
    } t_dvd;

    // Result of one divider lane.
    typedef struct packed {
        logic [DIV_BITS-1:0] q;
        logic                rnd;
        logic                neg;
        logic                cap;
    } t_quot;

    // Partial state of a restoring division.
    typedef struct packed {
        logic [DVS_W-1:0]    rem;
        logic [DIV_BITS-1:0] low;
        logic [DIV_BITS-1:0] q;
    } t_div;

endpackage

>>> design/tcs_div_lane.sv
module tcs_div_lane import tcs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_dvd  i_req,
    output t_quot o_res
);

    t_div             r_st  [DIV_STAGES];
    logic [DVS_W-1:0] r_d   [DIV_STAGES];
    logic             r_neg [DIV_STAGES];
    logic             r_cap [DIV_STAGES];
    t_quot            r_res;
    t_div             n_init;

    function automatic t_div div_stage(t_div s, logic [DVS_W-1:0] d);
        t_div       o;
        logic [DVS_W:0] t;
        o = s;
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            t     = {o.rem, o.low[DIV_BITS-1]};
            o.low = {o.low[DIV_BITS-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                o.rem = DVS_W'(t - {1'b0, d});
                o.q   = {o.q[DIV_BITS-2:0], 1'b1};
            end else begin
                o.rem = t[DVS_W-1:0];
                o.q   = {o.q[DIV_BITS-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    // The bits above the quotient range start the remainder; they are below
    // the divisor whenever the quotient is not capped.
    always_comb begin
        n_init.rem = DVS_W'(i_req.m[DVD_W-1:DIV_BITS]);
        n_init.low = i_req.m[DIV_BITS-1:0];
        n_init.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0]  <= div_stage(n_init, i_req.d);
            r_d[0]   <= i_req.d;
            r_neg[0] <= i_req.neg;
            r_cap[0] <= i_req.cap;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_st[s]  <= div_stage(r_st[s-1], r_d[s-1]);
                r_d[s]   <= r_d[s-1];
                r_neg[s] <= r_neg[s-1];
                r_cap[s] <= r_cap[s-1];
            end
            r_res.q   <= r_st[DIV_STAGES-1].q;
            r_res.rnd <= {r_st[DIV_STAGES-1].rem, 1'b0} >= {1'b0, r_d[DIV_STAGES-1]};
            r_res.neg <= r_neg[DIV_STAGES-1];
            r_res.cap <= r_cap[DIV_STAGES-1];
        end
    end

    assign o_res = r_res;

endmodule

>>> design/tetrahedron_circumsphere.sv
// Circumsphere of a tetrahedron.
// Input channel: i_valid / o_stall with i_data holding the four vertices in
// signed Q8.8. Output channel: o_valid / i_stall with o_data holding the
// center in signed Q16.16, the squared radius in Q24.24 and two flags.
// A request is taken at a clock edge where valid is high and stall is low.
// Path from acceptance to o_valid: six stages of edge, product and sum
// arithmetic, three divider lanes of twenty stages with two restoring steps
// each plus a rounding stage, and three stages of center, squaring and
// radius. Without a stall one request is accepted every cycle; the rate
// is set by the divider pipeline, which takes a new quotient each cycle.
// While o_valid is high and i_stall is asserted the whole pipeline holds
// and o_stall follows i_stall, so nothing is dropped or repeated.
// Reset clears every stage valid bit; data registers are not reset.
// A zero triple product gives zero outputs with degenerate set.
module tetrahedron_circumsphere import tcs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam logic [40:0] QCAP  = 41'h100_0000_0000;
    localparam logic [47:0] R_MAX = 48'hFFFF_FFFF_FFFF;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_out_valid;
    logic r_dv [DIV_LAT];

    // Stage 1: edge vectors from vertex a.
    logic signed [16:0] r1_e [3][3];
    logic signed [15:0] r1_a [3];
    // Stage 2: products.
    logic signed [33:0] r2_sq [3][3];
    logic signed [33:0] r2_pp [3][3];
    logic signed [33:0] r2_pm [3][3];
    logic signed [16:0] r2_b  [3];
    logic signed [15:0] r2_a  [3];
    // Stage 3: lengths and cross products.
    logic        [34:0] r3_len [3];
    logic signed [34:0] r3_x   [3][3];
    logic signed [16:0] r3_b   [3];
    logic signed [15:0] r3_a   [3];
    // Stage 4: triple product terms and numerator terms.
    logic signed [51:0] r4_t [3];
    logic signed [70:0] r4_n [3][3];
    logic signed [15:0] r4_a [3];
    // Stage 5: sums.
    logic signed [53:0] r5_t;
    logic signed [71:0] r5_num [3];
    logic signed [15:0] r5_a   [3];
    // Stage 6: magnitudes for the dividers.
    t_dvd               r6_req [3];
    logic               r6_degen;
    logic signed [15:0] r6_a   [3];
    t_dvd               n6_req [3];
    logic [71:0]        n6_abs [3];
    logic [52:0]        n6_d;
    logic [53:0]        n6_tabs;
    // Sideband alongside the dividers.
    logic               r_sd_degen [DIV_LAT];
    logic signed [15:0] r_sd_a     [DIV_LAT][3];
    t_quot              w_quot [3];
    // Stage 7: signed offsets.
    logic signed [41:0] r7_off [3];
    logic [40:0]        r7_mag [3];
    logic               r7_degen;
    logic signed [15:0] r7_a   [3];
    logic [40:0]        n7_mag [3];
    // Stage 8: center and squares.
    logic signed [31:0] r8_c    [3];
    logic               r8_csat [3];
    logic [55:0]        r8_sq   [3];
    logic               r8_big;
    logic               r8_degen;
    logic signed [42:0] n8_c    [3];
    // Output.
    t_out               r_out;
    t_out               n_out;
    logic [57:0]        n_sum;
    logic [49:0]        n_rad;

    assign o_stall = r_out_valid && i_stall;
    assign en      = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < DIV_LAT; s++) r_dv[s] <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
            r_v5 <= r_v4; r_v6 <= r_v5;
            r_dv[0] <= r_v6;
            for (int s = 1; s < DIV_LAT; s++) r_dv[s] <= r_dv[s-1];
            r_v7 <= r_dv[DIV_LAT-1];
            r_v8 <= r_v7;
            r_out_valid <= r_v8;
        end
    end

    always_comb begin
        n6_tabs = r5_t[53] ? 54'(-r5_t) : r5_t;
        n6_d    = n6_tabs[52:0];
        for (int k = 0; k < 3; k++) begin
            n6_abs[k]     = r5_num[k][71] ? 72'(-r5_num[k]) : r5_num[k];
            n6_req[k].m   = {n6_abs[k][70:0], 7'b0};
            n6_req[k].d   = n6_d;
            n6_req[k].neg = r5_num[k][71] ^ r5_t[53];
            // The quotient reaches 2^40 exactly when the top bits reach d.
            n6_req[k].cap = {15'b0, n6_req[k].m[DVD_W-1:DIV_BITS]} >= n6_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a[0] <= i_data.a_x; r1_a[1] <= i_data.a_y; r1_a[2] <= i_data.a_z;
            r1_e[0][0] <= {i_data.b_x[15], i_data.b_x} - {i_data.a_x[15], i_data.a_x};
            r1_e[0][1] <= {i_data.b_y[15], i_data.b_y} - {i_data.a_y[15], i_data.a_y};
            r1_e[0][2] <= {i_data.b_z[15], i_data.b_z} - {i_data.a_z[15], i_data.a_z};
            r1_e[1][0] <= {i_data.c_x[15], i_data.c_x} - {i_data.a_x[15], i_data.a_x};
            r1_e[1][1] <= {i_data.c_y[15], i_data.c_y} - {i_data.a_y[15], i_data.a_y};
            r1_e[1][2] <= {i_data.c_z[15], i_data.c_z} - {i_data.a_z[15], i_data.a_z};
            r1_e[2][0] <= {i_data.d_x[15], i_data.d_x} - {i_data.a_x[15], i_data.a_x};
            r1_e[2][1] <= {i_data.d_y[15], i_data.d_y} - {i_data.a_y[15], i_data.a_y};
            r1_e[2][2] <= {i_data.d_z[15], i_data.d_z} - {i_data.a_z[15], i_data.a_z};

            // Cross pair p is (c x d), (d x b), (b x c): edges p+1 and p+2.
            for (int p = 0; p < 3; p++) begin
                for (int k = 0; k < 3; k++) begin
                    r2_sq[p][k] <= 34'(r1_e[p][k]) * 34'(r1_e[p][k]);
                    r2_pp[p][k] <= 34'(r1_e[(p+1)%3][(k+1)%3]) * 34'(r1_e[(p+2)%3][(k+2)%3]);
                    r2_pm[p][k] <= 34'(r1_e[(p+2)%3][(k+1)%3]) * 34'(r1_e[(p+1)%3][(k+2)%3]);
                end
                r2_b[p] <= r1_e[0][p];
                r2_a[p] <= r1_a[p];
            end

            for (int p = 0; p < 3; p++) begin
                r3_len[p] <= 35'(r2_sq[p][0]) + 35'(r2_sq[p][1]) + 35'(r2_sq[p][2]);
                for (int k = 0; k < 3; k++)
                    r3_x[p][k] <= 35'(r2_pp[p][k]) - 35'(r2_pm[p][k]);
                r3_b[p] <= r2_b[p];
                r3_a[p] <= r2_a[p];
            end

            for (int k = 0; k < 3; k++) begin
                r4_t[k] <= 52'(r3_b[k]) * 52'(r3_x[0][k]);
                for (int p = 0; p < 3; p++)
                    r4_n[k][p] <= 71'(signed'({1'b0, r3_len[p]})) * 71'(r3_x[p][k]);
                r4_a[k] <= r3_a[k];
            end

            r5_t <= 54'(r4_t[0]) + 54'(r4_t[1]) + 54'(r4_t[2]);
            for (int k = 0; k < 3; k++) begin
                r5_num[k] <= 72'(r4_n[k][0]) + 72'(r4_n[k][1]) + 72'(r4_n[k][2]);
                r5_a[k]   <= r4_a[k];
            end

            r6_degen <= (r5_t == '0);
            for (int k = 0; k < 3; k++) begin
                r6_req[k] <= n6_req[k];
                r6_a[k]   <= r5_a[k];
            end

            r_sd_degen[0] <= r6_degen;
            for (int k = 0; k < 3; k++) r_sd_a[0][k] <= r6_a[k];
            for (int s = 1; s < DIV_LAT; s++) begin
                r_sd_degen[s] <= r_sd_degen[s-1];
                for (int k = 0; k < 3; k++) r_sd_a[s][k] <= r_sd_a[s-1][k];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        tcs_div_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_req (r6_req[g]),
            .o_res (w_quot[g])
        );
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n7_mag[k] = w_quot[k].cap ? QCAP : {1'b0, w_quot[k].q} + 41'(w_quot[k].rnd);
            n8_c[k]   = 43'(r7_off[k]) + {{19{r7_a[k][15]}}, r7_a[k], 8'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_degen <= r_sd_degen[DIV_LAT-1];
            for (int k = 0; k < 3; k++) begin
                r7_mag[k] <= n7_mag[k];
                r7_off[k] <= w_quot[k].neg ? -42'(signed'({1'b0, n7_mag[k]}))
                                           : 42'(signed'({1'b0, n7_mag[k]}));
                r7_a[k]   <= r_sd_a[DIV_LAT-1][k];
            end

            r8_degen <= r7_degen;
            r8_big   <= (|r7_mag[0][40:28]) || (|r7_mag[1][40:28]) || (|r7_mag[2][40:28]);
            for (int k = 0; k < 3; k++) begin
                r8_sq[k] <= 56'(r7_mag[k][27:0]) * 56'(r7_mag[k][27:0]);
                if (n8_c[k][42:31] != {12{n8_c[k][42]}}) begin
                    r8_c[k]    <= {n8_c[k][42], {31{~n8_c[k][42]}}};
                    r8_csat[k] <= 1'b1;
                end else begin
                    r8_c[k]    <= n8_c[k][31:0];
                    r8_csat[k] <= 1'b0;
                end
            end

            r_out <= n_out;
        end
    end

    always_comb begin
        n_sum = 58'(r8_sq[0]) + 58'(r8_sq[1]) + 58'(r8_sq[2]) + 58'd128;
        n_rad = n_sum[57:8];
        n_out.center_x   = r8_c[0];
        n_out.center_y   = r8_c[1];
        n_out.center_z   = r8_c[2];
        n_out.degenerate = 1'b0;
        n_out.saturated  = r8_csat[0] || r8_csat[1] || r8_csat[2];
        if (r8_big || n_rad[49:48] != 2'b00) begin
            n_out.radius_sq = R_MAX;
            n_out.saturated = 1'b1;
        end else begin
            n_out.radius_sq = n_rad[47:0];
        end
        if (r8_degen) begin
            n_out = '0;
            n_out.degenerate = 1'b1;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef NO_ASSERTIONS
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |-> o_data.center_x == 0 && o_data.center_y == 0 &&
            o_data.center_z == 0 && o_data.radius_sq == 0 && !o_data.saturated)
        else $error("degenerate result carries nonzero data");
    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a waiting result");
    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_v1) && $stable(r_dv[0]) && $stable(r_v8))
        else $error("pipeline moved during a stall");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tcs_pkg::*;

    localparam int LATENCY     = 30;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1500;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    tetrahedron_circumsphere DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    t_in  pending_tetra[$];
    t_out expected_sphere[$];
    int   errors = 0;
    int   cycles = 0;
    int   accepted = 0;
    int   received = 0;
    int   n_degenerate = 0;
    int   n_saturated = 0;
    bit   sender_hold = 0;
    bit   recv_quiet = 0;
    int   hold_cycles = 0;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Rounded quotient of num * 2^7 / t, ties away from zero, clamped at 2^40.
    function automatic longint offset_quotient(logic signed [127:0] num, longint t);
        logic [127:0] mag;
        logic [127:0] den;
        logic [127:0] q;
        logic [127:0] r;
        bit neg;
        neg = (num < 0) != (t < 0);
        mag = (num < 0) ? -num : num;
        mag = mag << 7;
        den = (t < 0) ? -t : t;
        q = mag / den;
        r = mag % den;
        if (q >= (128'd1 << 40)) q = 128'd1 << 40;
        else if (2 * r >= den) q = q + 1;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_out circumsphere(t_in v);
        t_out o;
        longint ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz;
        longint lb, lc, ld, t, cen;
        longint cd[3], db[3], bc[3], av[3], off[3];
        logic [127:0] sum;
        logic [127:0] rad;
        logic signed [127:0] num;
        bit sat, big;
        ax = v.a_x; ay = v.a_y; az = v.a_z;
        bx = v.b_x - ax; by = v.b_y - ay; bz = v.b_z - az;
        cx = v.c_x - ax; cy = v.c_y - ay; cz = v.c_z - az;
        dx = v.d_x - ax; dy = v.d_y - ay; dz = v.d_z - az;
        lb = bx*bx + by*by + bz*bz;
        lc = cx*cx + cy*cy + cz*cz;
        ld = dx*dx + dy*dy + dz*dz;
        cd[0] = cy*dz - dy*cz; cd[1] = cz*dx - dz*cx; cd[2] = cx*dy - dx*cy;
        db[0] = dy*bz - by*dz; db[1] = dz*bx - bz*dx; db[2] = dx*by - bx*dy;
        bc[0] = by*cz - cy*bz; bc[1] = bz*cx - cz*bx; bc[2] = bx*cy - cx*by;
        t = bx*cd[0] + by*cd[1] + bz*cd[2];
        o = '0;
        if (t == 0) begin
            o.degenerate = 1'b1;
            return o;
        end
        av[0] = ax; av[1] = ay; av[2] = az;
        sat = 0;
        big = 0;
        for (int k = 0; k < 3; k++) begin
            num = 128'(signed'(lb)) * 128'(signed'(cd[k]))
                + 128'(signed'(lc)) * 128'(signed'(db[k]))
                + 128'(signed'(ld)) * 128'(signed'(bc[k]));
            off[k] = offset_quotient(num, t);
            cen = off[k] + av[k] * 256;
            if (cen > 64'sd2147483647) begin cen = 64'sd2147483647; sat = 1; end
            if (cen < -64'sd2147483648) begin cen = -64'sd2147483648; sat = 1; end
            if (k == 0) o.center_x = cen[31:0];
            if (k == 1) o.center_y = cen[31:0];
            if (k == 2) o.center_z = cen[31:0];
            if (off[k] >= (64'sd1 << 28) || off[k] <= -(64'sd1 << 28)) big = 1;
        end
        if (big) begin
            o.radius_sq = '1;
            sat = 1;
        end else begin
            sum = 0;
            for (int k = 0; k < 3; k++)
                sum += 128'(off[k] * off[k]);
            rad = (sum + 128) >> 8;
            if (rad > 128'hFFFF_FFFF_FFFF) begin
                rad = 128'hFFFF_FFFF_FFFF;
                sat = 1;
            end
            o.radius_sq = rad[47:0];
        end
        o.saturated = sat;
        return o;
    endfunction

    function automatic logic signed [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 2047)) - 16'sd1024;
            2: return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom_range(0, 31)) - 16'sd16;
        endcase
    endfunction

    task automatic push_tetra(t_in v);
        pending_tetra.push_back(v);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("tetrahedron_circumsphere regression: fail");
            $finish;
        end
    end

    // Driver: new request goes out at the falling edge once the old one was taken.
    bit drv_taken;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (drv_taken || !i_valid) begin
                if (pending_tetra.size() > 0 && !sender_hold &&
                    (cycles % 2000 < 400 || $urandom_range(0, 99) >= 25)) begin
                    i_data  <= pending_tetra.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                    i_data  <= t_in'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
                end
            end
            if (recv_quiet) i_stall <= 1'b1;
            else i_stall <= (cycles % 2000 >= 400) && ($urandom_range(0, 99) < 25);
        end
    end

    always @(posedge i_clk) begin
        drv_taken = i_rst_n && i_valid && !o_stall;
        if (drv_taken) begin
            expected_sphere.push_back(circumsphere(i_data));
            accepted <= accepted + 1;
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            received <= received + 1;
            if (expected_sphere.size() == 0) begin
                errors <= errors + 1;
                $display("%0t unexpected result %h", $time, o_data);
            end else begin
                e = expected_sphere.pop_front();
                if (e.degenerate) n_degenerate <= n_degenerate + 1;
                if (e.saturated) n_saturated <= n_saturated + 1;
                if (o_data.center_x !== e.center_x || o_data.center_y !== e.center_y ||
                    o_data.center_z !== e.center_z || o_data.radius_sq !== e.radius_sq ||
                    o_data.degenerate !== e.degenerate ||
                    o_data.saturated !== e.saturated) begin
                    errors <= errors + 1;
                    $display("%0t mismatch: expected c=(%0d,%0d,%0d) r=%0d deg=%b sat=%b",
                             $time, e.center_x, e.center_y, e.center_z, e.radius_sq,
                             e.degenerate, e.saturated);
                    $display("%0t            actual c=(%0d,%0d,%0d) r=%0d deg=%b sat=%b",
                             $time, o_data.center_x, o_data.center_y, o_data.center_z,
                             o_data.radius_sq, o_data.degenerate, o_data.saturated);
                end
            end
        end
    end

    // Receiver holds off long enough for the pipeline to fill and back up.
    always @(posedge i_clk) begin
        if (recv_quiet) begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 3 * LATENCY) recv_quiet <= 1'b0;
        end
    end

    initial begin
        t_in v;
        int mode;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data  = '0;
        drv_taken = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: right-corner tetrahedron, flat ones, coordinate extremes.
        v = '0; v.b_x = 16'sh0100; v.c_y = 16'sh0100; v.d_z = 16'sh0100; push_tetra(v);
        v = '0; push_tetra(v);
        v = '0; v.b_x = 16'sh0100; v.c_x = 16'sh0200; v.d_x = 16'sh0300; push_tetra(v);
        v = '0; v.b_x = 16'sh0100; v.c_y = 16'sh0100; v.d_x = 16'sh0100;
        v.d_y = 16'sh0100; push_tetra(v);
        v = '0; v.b_x = 16'sh7FFF; v.c_y = 16'sh7FFF; v.d_z = 16'sh7FFF; push_tetra(v);
        v = '0; v.a_x = 16'sh8000; v.a_y = 16'sh8000; v.a_z = 16'sh8000;
        v.b_x = 16'sh7FFF; v.b_y = 16'sh8000; v.b_z = 16'sh8000;
        v.c_x = 16'sh8000; v.c_y = 16'sh7FFF; v.c_z = 16'sh8000;
        v.d_x = 16'sh8000; v.d_y = 16'sh8000; v.d_z = 16'sh7FFF; push_tetra(v);
        // Nearly flat sliver: tiny triple product, huge center.
        v = '0; v.b_x = 16'sh7FFF; v.c_y = 16'sh7FFF; v.d_x = 16'sh4000;
        v.d_y = 16'sh4000; v.d_z = 16'sh0001; push_tetra(v);
        v = '0; v.a_x = 16'sh7FFF; v.a_y = 16'sh7FFF; v.a_z = 16'sh7FFF;
        v.b_x = 16'sh7FFE; v.b_y = 16'sh7FFF; v.b_z = 16'sh7FFF;
        v.c_x = 16'sh7FFF; v.c_y = 16'sh7FFE; v.c_z = 16'sh7FFF;
        v.d_x = 16'sh7FFF; v.d_y = 16'sh7FFF; v.d_z = 16'sh7FFE; push_tetra(v);
        v = '0; v.b_x = 16'sh0001; v.c_y = 16'sh0001; v.d_z = 16'sh0001; push_tetra(v);
        v = '1; push_tetra(v);
        for (int i = 0; i < 10; i++) begin
            v = '0;
            for (int j = 0; j < 12; j++) v[j*16 +: 16] = rand_coord(2);
            push_tetra(v);
        end

        wait (pending_tetra.size() == 0);
        recv_quiet = 1'b1;
        for (int i = 0; i < N_RANDOM; i++) begin
            v = '0;
            mode = $urandom_range(0, 9);
            for (int j = 0; j < 12; j++)
                v[j*16 +: 16] = rand_coord(mode < 5 ? 0 : (mode < 8 ? 1 : (mode - 6)));
            if ($urandom_range(0, 19) == 0) v.d_x = v.b_x + v.c_x - v.a_x;
            if ($urandom_range(0, 19) == 0) begin
                v.d_x = v.b_x; v.d_y = v.b_y; v.d_z = v.b_z;
            end
            push_tetra(v);
            if (i == N_RANDOM / 2) begin
                wait (pending_tetra.size() == 0);
                sender_hold = 1'b1;
                wait (expected_sphere.size() == 0 && accepted > 0);
                repeat (5) @(posedge i_clk);
                sender_hold = 1'b0;
            end
        end
        wait (pending_tetra.size() == 0);
        @(posedge i_clk);
        wait (expected_sphere.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d tetrahedra: %0d flat, %0d clipped, with random stalls",
                 received, n_degenerate, n_saturated);
        if (errors == 0 && expected_sphere.size() == 0) begin
            $display("tetrahedron_circumsphere regression: pass");
        end else begin
            $display("tetrahedron_circumsphere regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
design/tcs_pkg.sv
design/tcs_div_lane.sv
design/tetrahedron_circumsphere.sv
tb/sv/testbench.sv
